// ===== sv/pad_pkg.sv =====
package pad_pkg;

  localparam int COORD_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS        = 24;
  localparam int ANGLE_WIDTH      = 32;
  localparam int OUT_WIDTH        = 16;

  localparam logic [ANGLE_WIDTH-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [ANGLE_WIDTH-1:0] ROUND_HALF   = 32'h0000_8000;

  // atan(2^-i) as a fraction of a full turn, 2^32 per turn
  function automatic logic [ANGLE_WIDTH-1:0] atan_turn(input int idx);
    logic [ANGLE_WIDTH-1:0] a;
    case (idx)
      0:       a = 32'h2000_0000;
      1:       a = 32'h12E4_051D;
      2:       a = 32'h09FB_385B;
      3:       a = 32'h0511_11D4;
      4:       a = 32'h028B_0D43;
      5:       a = 32'h0145_D7E1;
      6:       a = 32'h00A2_F61E;
      7:       a = 32'h0051_7C55;
      8:       a = 32'h0028_BE53;
      9:       a = 32'h0014_5F2E;
      10:      a = 32'h000A_2F98;
      11:      a = 32'h0005_17CC;
      12:      a = 32'h0002_8BE6;
      13:      a = 32'h0001_45F3;
      14:      a = 32'h0000_A2F9;
      15:      a = 32'h0000_517C;
      16:      a = 32'h0000_28BE;
      17:      a = 32'h0000_145F;
      18:      a = 32'h0000_0A2F;
      19:      a = 32'h0000_0517;
      20:      a = 32'h0000_028B;
      21:      a = 32'h0000_0145;
      22:      a = 32'h0000_00A2;
      23:      a = 32'h0000_0051;
      24:      a = 32'h0000_0028;
      25:      a = 32'h0000_0014;
      26:      a = 32'h0000_000A;
      27:      a = 32'h0000_0005;
      28:      a = 32'h0000_0002;
      29:      a = 32'h0000_0001;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/pad_prep.sv =====
module pad_prep #(
  parameter int CW = pad_pkg::COORD_WIDTH_DEF,
  parameter int DW = pad_pkg::COORD_WIDTH_DEF + pad_pkg::FRAC_BITS + 3
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [CW-1:0]                 x_in,
  input  logic signed [CW-1:0]                 y_in,
  output logic signed [DW-1:0]                 x,
  output logic signed [DW-1:0]                 y,
  output logic        [pad_pkg::ANGLE_WIDTH-1:0] z,
  output logic                                 hold
);
  import pad_pkg::*;

  logic signed [DW-1:0]          xe;
  logic signed [DW-1:0]          ye;
  logic signed [DW-1:0]          x_next;
  logic signed [DW-1:0]          y_next;
  logic        [ANGLE_WIDTH-1:0] z_next;
  logic                          hold_next;

  assign xe = {{(DW-CW){x_in[CW-1]}}, x_in};
  assign ye = {{(DW-CW){y_in[CW-1]}}, y_in};

  // x on the axis: angle is fixed and the rotations leave it alone; negative x is negated and starts at a half turn
  always_comb begin
    hold_next = 1'b0;
    z_next    = '0;
    x_next    = xe <<< FRAC_BITS;
    y_next    = ye <<< FRAC_BITS;
    if (x_in == '0) begin
      hold_next = 1'b1;
      if (y_in == '0) begin
        z_next = '0;
      end else if (y_in[CW-1]) begin
        z_next = ANGLE_WIDTH'(0) - QUARTER_TURN;
      end else begin
        z_next = QUARTER_TURN;
      end
    end else if (x_in[CW-1]) begin
      z_next = HALF_TURN;
      x_next = (-xe) <<< FRAC_BITS;
      y_next = (-ye) <<< FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
      hold <= hold_next;
    end
  end

endmodule

// ===== sv/pad_step.sv =====
module pad_step #(
  parameter int DW  = pad_pkg::COORD_WIDTH_DEF + pad_pkg::FRAC_BITS + 3,
  parameter int IDX = 0
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [DW-1:0]                   x_in,
  input  logic signed [DW-1:0]                   y_in,
  input  logic        [pad_pkg::ANGLE_WIDTH-1:0] z_in,
  input  logic                                   hold_in,
  output logic signed [DW-1:0]                   x,
  output logic signed [DW-1:0]                   y,
  output logic        [pad_pkg::ANGLE_WIDTH-1:0] z,
  output logic                                   hold
);
  import pad_pkg::*;

  localparam logic [ANGLE_WIDTH-1:0] ATAN = atan_turn(IDX);

  logic signed [DW-1:0]          xs;
  logic signed [DW-1:0]          ys;
  logic signed [DW-1:0]          x_next;
  logic signed [DW-1:0]          y_next;
  logic        [ANGLE_WIDTH-1:0] z_next;

  assign xs = x_in >>> IDX;
  assign ys = y_in >>> IDX;

  always_comb begin
    if (!y_in[DW-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = hold_in ? z_in : z_in + ATAN;
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = hold_in ? z_in : z_in - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
      hold <= hold_in;
    end
  end

endmodule

// ===== sv/planar_angle_difference.sv =====
// Pipeline: one conditioning stage, one stage per CORDIC micro-rotation and
// one output stage.
// Throughput: one request per cycle; the whole pipeline holds while out_stall
// is high and a result is waiting.
// Reset: synchronous, clears all valid bits; the data path is not reset.
module planar_angle_difference #(
  parameter int COORD_WIDTH  = pad_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = pad_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [COORD_WIDTH-1:0]        first_x,
  input  logic signed [COORD_WIDTH-1:0]        first_y,
  input  logic signed [COORD_WIDTH-1:0]        second_x,
  input  logic signed [COORD_WIDTH-1:0]        second_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pad_pkg::OUT_WIDTH-1:0] angle_difference
);
  import pad_pkg::*;

  localparam int DW = COORD_WIDTH + FRAC_BITS + 3;

  logic                          adv;
  logic [CORDIC_STEPS:0]         vld;
  logic signed [DW-1:0]          xa [2][CORDIC_STEPS+1];
  logic signed [DW-1:0]          ya [2][CORDIC_STEPS+1];
  logic        [ANGLE_WIDTH-1:0] za [2][CORDIC_STEPS+1];
  logic                          ha [2][CORDIC_STEPS+1];
  logic        [ANGLE_WIDTH-1:0] diff;
  logic        [ANGLE_WIDTH-1:0] rounded;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  pad_prep #(.CW(COORD_WIDTH), .DW(DW)) u_prep_first (
    .clk(clk), .en(adv), .x_in(first_x), .y_in(first_y),
    .x(xa[0][0]), .y(ya[0][0]), .z(za[0][0]), .hold(ha[0][0])
  );

  pad_prep #(.CW(COORD_WIDTH), .DW(DW)) u_prep_second (
    .clk(clk), .en(adv), .x_in(second_x), .y_in(second_y),
    .x(xa[1][0]), .y(ya[1][0]), .z(za[1][0]), .hold(ha[1][0])
  );

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
      pad_step #(.DW(DW), .IDX(s)) u_step (
        .clk(clk), .en(adv),
        .x_in(xa[l][s]), .y_in(ya[l][s]), .z_in(za[l][s]), .hold_in(ha[l][s]),
        .x(xa[l][s+1]), .y(ya[l][s+1]), .z(za[l][s+1]), .hold(ha[l][s+1])
      );
    end
  end

  assign diff    = za[1][CORDIC_STEPS] - za[0][CORDIC_STEPS];
  assign rounded = diff + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[CORDIC_STEPS-1:0], in_valid};
      out_valid <= vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angle_difference <= rounded[ANGLE_WIDTH-1 -: OUT_WIDTH];
    end
  end

  a_free_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input held while output is free");

  a_request_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted request lost at pipeline entry");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(vld) && out_valid)
    else $error("pipeline moved while output stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && vld == '0)
    else $error("valid bits not cleared by reset");

endmodule

// ===== tb/tb.sv =====
package angle_check_pkg;

  localparam int CW    = pad_pkg::COORD_WIDTH_DEF;
  localparam int STEPS = (pad_pkg::CORDIC_STEPS_DEF > 32) ? 32 : pad_pkg::CORDIC_STEPS_DEF;

  // atan(2^-i) in turns, 2^32 per turn
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2E, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
    32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051,
    32'h0000_0028, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0002, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000
  };

  class angle_diff_scoreboard;
    logic signed [pad_pkg::OUT_WIDTH-1:0] pending_diffs[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    static function logic [31:0] vector_turn(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy);
      longint x;
      longint y;
      longint xs;
      longint ys;
      logic [31:0] z;
      x = cx;
      y = cy;
      z = '0;
      if (x == 0 && y == 0) return '0;
      if (x == 0) return (y > 0) ? pad_pkg::QUARTER_TURN : -pad_pkg::QUARTER_TURN;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = pad_pkg::HALF_TURN;
      end
      x = x <<< pad_pkg::FRAC_BITS;
      y = y <<< pad_pkg::FRAC_BITS;
      for (int i = 0; i < STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_TURNS[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_TURNS[i];
        end
      end
      return z;
    endfunction

    function void note_request(logic signed [CW-1:0] fx, logic signed [CW-1:0] fy,
                               logic signed [CW-1:0] sx, logic signed [CW-1:0] sy);
      logic [31:0] turn_diff;
      logic [31:0] rounded;
      turn_diff = vector_turn(sx, sy) - vector_turn(fx, fy);
      rounded   = turn_diff + pad_pkg::ROUND_HALF;
      pending_diffs.push_back(rounded[31:16]);
    endfunction

    function void check_result(logic signed [pad_pkg::OUT_WIDTH-1:0] actual);
      logic signed [pad_pkg::OUT_WIDTH-1:0] want;
      if (pending_diffs.size() == 0) begin
        failures++;
        $display("%0t angle_difference: expected none, actual %0d", $time, actual);
      end else begin
        want = pending_diffs.pop_front();
        if (actual !== want) begin
          failures++;
          $display("%0t angle_difference: expected %0d, actual %0d", $time, want, actual);
        end
      end
    endfunction

    function int pending();
      return pending_diffs.size();
    endfunction
  endclass

endpackage

module tb;
  import angle_check_pkg::*;

  localparam int LATENCY         = pad_pkg::CORDIC_STEPS_DEF + 2;
  localparam int IDLE_LIMIT      = 5000;
  localparam int RANDOM_REQUESTS = 928;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] first_x = '0;
  logic signed [CW-1:0] first_y = '0;
  logic signed [CW-1:0] second_x = '0;
  logic signed [CW-1:0] second_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [pad_pkg::OUT_WIDTH-1:0] angle_difference;

  angle_diff_scoreboard sb;
  int burst_left = 1;
  int idle_cycles = 0;
  int stall_tick = 0;
  stall_mode_t stall_mode = STALL_NONE;

  planar_angle_difference uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .first_x(first_x),
    .first_y(first_y),
    .second_x(second_x),
    .second_y(second_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .angle_difference(angle_difference)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 300 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     out_stall = 1'b0;
      STALL_LIGHT:    out_stall = ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall = ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall = ((stall_tick % 5) < 2);
      default:        out_stall = 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (in_valid && !in_stall) sb.note_request(first_x, first_y, second_x, second_y);
      if (out_valid && !out_stall) sb.check_result(angle_difference);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // bursts of requests with random gaps between them
  task automatic send_request(logic signed [CW-1:0] fx, logic signed [CW-1:0] fy,
                              logic signed [CW-1:0] sx, logic signed [CW-1:0] sy);
    @(negedge clk);
    first_x  = fx;
    first_y  = fy;
    second_x = sx;
    second_y = sy;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] pick_coord();
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = int'($urandom_range(0, 8)) - 4;
      2: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          2: v = -1;
          default: v = 1;
        endcase
      end
      default: v = $urandom_range(0, 65535);
    endcase
    return v[CW-1:0];
  endfunction

  initial begin
    logic signed [CW-1:0] fx;
    logic signed [CW-1:0] fy;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_request(1, 0, 0, 1);
    send_request(1, 0, 0, -1);
    send_request(0, 0, 0, 0);
    send_request(0, 0, 123, -456);
    send_request(-5, 7, 0, 0);
    send_request(1, 0, -1, 0);
    send_request(-1, 0, 1, 0);
    send_request(32767, 0, -32768, 0);
    send_request(0, 32767, 0, -32768);
    send_request(0, -32768, 0, 32767);
    send_request(-32768, -32768, 32767, 32767);
    send_request(32767, 32767, -32768, -32768);
    send_request(-32768, 32767, 32767, -32768);
    send_request(32767, -32768, -32768, 32767);
    send_request(-1, -1, -1, 1);
    send_request(-32768, 0, -32768, -1);
    send_request(-32768, 1, -32768, -1);
    send_request(1, 32767, -1, 32767);
    send_request(32767, 1, 32767, -1);
    send_request(-1, 0, -1, 0);
    send_request(0, 1, -32768, 0);
    send_request(-32768, 0, 0, -1);
    drain();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      fx = pick_coord();
      fy = pick_coord();
      case ($urandom_range(0, 19))
        0, 1: begin
          sx = fx;
          sy = fy;
        end
        2: begin
          sx = -fx;
          sy = -fy;
        end
        default: begin
          sx = pick_coord();
          sy = pick_coord();
        end
      endcase
      send_request(fx, fy, sx, sy);
      if (n == RANDOM_REQUESTS / 2) drain();
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pad_pkg.sv
sv/pad_prep.sv
sv/pad_step.sv
sv/planar_angle_difference.sv
tb/tb.sv
